// ===== rtl/core/rfc_pkg.sv =====
// Package for the response frame checker: frame constants, status codes,
// register indexes, the result entry type and the CRC-16 byte update.
// No dependencies.
package rfc_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int HDR_BYTES       = 10;
    localparam int HDR_IDX_W       = $clog2(HDR_BYTES);
    localparam int BYTE_COUNT_W    = $clog2(MAX_FRAME_BYTES + 1);

    localparam logic [15:0] FRAME_MAGIC = 16'h55AA;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;

    localparam logic [BYTE_COUNT_W-1:0] HDR_BYTES_C   = BYTE_COUNT_W'(HDR_BYTES);
    localparam logic [BYTE_COUNT_W-1:0] MAX_FRAME_C   = BYTE_COUNT_W'(MAX_FRAME_BYTES);
    localparam logic [15:0]             MAX_PAYLOAD_C = 16'(MAX_FRAME_BYTES - HDR_BYTES);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_TYPE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_SEQUENCE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHECK_SEQUENCE    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COPY_LIMIT        = 2'd3;

    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_SHORT    = 3'd1;
    localparam logic [2:0] STATUS_MAGIC    = 3'd2;
    localparam logic [2:0] STATUS_TYPE     = 3'd3;
    localparam logic [2:0] STATUS_SEQUENCE = 3'd4;
    localparam logic [2:0] STATUS_LENGTH   = 3'd5;
    localparam logic [2:0] STATUS_CHECKSUM = 3'd6;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic       kind;
        logic [7:0] payload;
        logic [2:0] status;
        logic       eor;
    } result_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/response_frame_checker_top.sv =====
// Response frame checker top level: input register, frame parser with CRC,
// and a four-entry result queue. Depends on rfc_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) moves one received byte per transfer,
//   with first_byte restarting the parser and last_byte closing the frame.
//   Output channel (out_valid/out_ready) moves one result per transfer:
//   a payload byte (out_kind 0) or the frame verdict (out_kind 1,
//   end_of_run 1). A closing byte that also carries payload yields two
//   results, payload first.
//   Configuration channel (cfg_valid/cfg_ready) writes one register per
//   transfer; cfg_ready is always high. Write only while the block is idle.
//   An input byte waits in the input register until the parser step fires
//   and writes its results into the result queue. Throughput: one input byte
//   per cycle while two queue entries are free, with the parser step and its
//   unrolled CRC byte update combinational; one result leaves per cycle while
//   out_ready is high, and the queue absorbs a closing byte's extra result.
//   Reset clears the parser, the queue and restores the register defaults.
//   When the receiver stalls, the queue fills and in_ready drops once
//   fewer than two entries are free; nothing is lost.
module response_frame_checker_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       rx_byte,
    input  logic                             first_byte,
    input  logic                             last_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             out_kind,
    output logic [7:0]                       payload_byte,
    output logic [2:0]                       status,
    output logic                             end_of_run,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rfc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rfc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rfc_pkg::*;

    logic [7:0]  expected_type_reg;
    logic [15:0] expected_sequence_reg;
    logic        check_sequence_reg;
    logic [7:0]  copy_limit_reg;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_first_reg;
    logic        s1_last_reg;
    logic        s1_fire;

    logic [BYTE_COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [15:0]             crc_reg, crc_next;
    logic [7:0]              payload_count_reg, payload_count_next;
    logic [7:0]              hdr_reg  [HDR_BYTES];
    logic [7:0]              hdr_next [HDR_BYTES];

    result_t               fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  pop;
    logic [1:0]            push_n;
    result_t               push0, push1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            expected_type_reg     <= 8'd2;
            expected_sequence_reg <= 16'd0;
            check_sequence_reg    <= 1'b1;
            copy_limit_reg        <= 8'd246;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_EXPECTED_TYPE:     expected_type_reg     <= cfg_data[7:0];
                REG_EXPECTED_SEQUENCE: expected_sequence_reg <= cfg_data[15:0];
                REG_CHECK_SEQUENCE:    check_sequence_reg    <= cfg_data[0];
                REG_COPY_LIMIT:        copy_limit_reg        <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign s1_fire  = s1_valid_reg && (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign in_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && in_ready) begin
            s1_byte_reg  <= rx_byte;
            s1_first_reg <= first_byte;
            s1_last_reg  <= last_byte;
        end
    end

    always_comb begin
        logic [BYTE_COUNT_W-1:0] bc;
        logic [BYTE_COUNT_W-1:0] p;
        logic [15:0]             crc;
        logic [7:0]              pc;
        logic [15:0]             len;
        logic [15:0]             magic;
        logic [15:0]             seq;
        logic [15:0]             chk;
        logic                    emit;
        logic [2:0]              verdict;

        bc  = s1_first_reg ? '0 : byte_count_reg;
        crc = s1_first_reg ? CRC_INIT : crc_reg;
        pc  = s1_first_reg ? 8'd0 : payload_count_reg;
        for (int i = 0; i < HDR_BYTES; i++) begin
            hdr_next[i] = hdr_reg[i];
        end
        len  = {hdr_reg[7], hdr_reg[6]};
        p    = bc - HDR_BYTES_C;
        emit = 1'b0;

        if (bc < MAX_FRAME_C) begin
            if (bc < HDR_BYTES_C) begin
                hdr_next[bc[HDR_IDX_W-1:0]] = s1_byte_reg;
            end else if (16'(p) < len) begin
                crc = crc16_byte(crc, s1_byte_reg);
                if (pc < copy_limit_reg) begin
                    pc   = pc + 8'd1;
                    emit = 1'b1;
                end
            end
            bc = bc + BYTE_COUNT_W'(1);
        end

        magic = {hdr_next[1], hdr_next[0]};
        seq   = {hdr_next[5], hdr_next[4]};
        len   = {hdr_next[7], hdr_next[6]};
        chk   = {hdr_next[9], hdr_next[8]};

        if (bc < HDR_BYTES_C) begin
            verdict = STATUS_SHORT;
        end else if (magic != FRAME_MAGIC) begin
            verdict = STATUS_MAGIC;
        end else if (hdr_next[3] != expected_type_reg) begin
            verdict = STATUS_TYPE;
        end else if (check_sequence_reg && (seq != expected_sequence_reg)) begin
            verdict = STATUS_SEQUENCE;
        end else if ((len > 16'(bc - HDR_BYTES_C)) || (len > MAX_PAYLOAD_C)) begin
            verdict = STATUS_LENGTH;
        end else if (crc != chk) begin
            verdict = STATUS_CHECKSUM;
        end else begin
            verdict = STATUS_OK;
        end

        push0 = '{kind: KIND_PAYLOAD, payload: s1_byte_reg, status: STATUS_OK, eor: 1'b0};
        push1 = '{kind: KIND_VERDICT, payload: 8'd0, status: verdict, eor: 1'b1};
        if (!emit) begin
            push0 = push1;
        end
        push_n = s1_fire ? ({1'b0, emit} + {1'b0, s1_last_reg}) : 2'd0;

        if (s1_last_reg) begin
            byte_count_next    = '0;
            crc_next           = CRC_INIT;
            payload_count_next = 8'd0;
        end else begin
            byte_count_next    = bc;
            crc_next           = crc;
            payload_count_next = pc;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            byte_count_reg    <= '0;
            crc_reg           <= CRC_INIT;
            payload_count_reg <= 8'd0;
        end else if (s1_fire) begin
            byte_count_reg    <= byte_count_next;
            crc_reg           <= crc_next;
            payload_count_reg <= payload_count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (s1_fire) begin
            for (int i = 0; i < HDR_BYTES; i++) begin
                hdr_reg[i] <= hdr_next[i];
            end
        end
    end

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk) begin
        if (push_n != 2'd0) begin
            fifo_mem[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            fifo_mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(pop);
            count_reg  <= count_reg + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
        end
    end

    assign out_kind     = fifo_mem[rd_ptr_reg].kind;
    assign payload_byte = fifo_mem[rd_ptr_reg].payload;
    assign status       = fifo_mem[rd_ptr_reg].status;
    assign end_of_run   = fifo_mem[rd_ptr_reg].eor;

endmodule

// ===== rtl/core/rfc_checker.sv =====
// Port-level checks for the response frame checker, bound to its top level.
// Depends on rfc_pkg and response_frame_checker_top.
module rfc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_kind,
    input logic [7:0] payload_byte,
    input logic [2:0] status,
    input logic       end_of_run
);
    import rfc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind)
            && $stable(payload_byte) && $stable(status) && $stable(end_of_run))
        else $error("result changed while stalled");

    a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_PAYLOAD) |-> (status == STATUS_OK) && !end_of_run)
        else $error("payload transfer carries verdict fields");

    a_verdict_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_VERDICT) |-> end_of_run && (payload_byte == 8'd0))
        else $error("verdict transfer malformed");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status != 3'd7))
        else $error("status code out of range");

endmodule

bind response_frame_checker_top rfc_checker u_rfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .payload_byte (payload_byte),
    .status       (status),
    .end_of_run   (end_of_run)
);

// ===== bench/rfc_result_checker.sv =====
// Result checker for the response frame checker: follows the input, output and
// register channels, predicts each result from a frame model of its own and
// compares in order. Depends on rfc_pkg for constants and the result type.
module rfc_result_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [7:0]                      rx_byte,
    input  logic                            first_byte,
    input  logic                            last_byte,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            out_kind,
    input  logic [7:0]                      payload_byte,
    input  logic [2:0]                      status,
    input  logic                            end_of_run,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [rfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatch_count,
    output int                              pending
);
    import rfc_pkg::*;

    localparam logic [7:0]  TYPE_AT_RESET  = 8'h02;
    localparam logic [15:0] SEQ_AT_RESET   = 16'h0000;
    localparam logic        CHECK_AT_RESET = 1'b1;
    localparam logic [7:0]  COPY_AT_RESET  = 8'd246;

    logic [7:0]              want_type;
    logic [15:0]             want_seq;
    logic                    seq_enabled;
    logic [7:0]              copy_max;

    logic [BYTE_COUNT_W-1:0] rx_count;
    logic [7:0]              header_bytes [HDR_BYTES];
    logic [15:0]             crc_run;
    logic [15:0]             copied;

    result_t                 awaited_results [$];

    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            r = (r >> 1) ^ (r[0] ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic logic [15:0] header_word(input int at);
        return {header_bytes[HDR_IDX_W'(at + 1)], header_bytes[HDR_IDX_W'(at)]};
    endfunction

    task automatic restart_frame();
        rx_count = '0;
        foreach (header_bytes[i]) header_bytes[i] = 8'h00;
        crc_run = CRC_INIT;
        copied = 16'h0000;
    endtask

    function automatic logic [2:0] frame_status();
        int received;
        if (rx_count < HDR_BYTES_C) return STATUS_SHORT;
        if (header_word(0) != FRAME_MAGIC) return STATUS_MAGIC;
        if (header_bytes[3] != want_type) return STATUS_TYPE;
        if (seq_enabled && header_word(4) != want_seq) return STATUS_SEQUENCE;
        received = int'(rx_count) - HDR_BYTES;
        if (int'(header_word(6)) > received || header_word(6) > MAX_PAYLOAD_C)
            return STATUS_LENGTH;
        if (crc_run != header_word(8)) return STATUS_CHECKSUM;
        return STATUS_OK;
    endfunction

    task automatic predict_frame_results(input logic [7:0] b, input logic f, input logic l);
        int      offset;
        result_t r;
        if (f) restart_frame();
        if (rx_count < MAX_FRAME_C) begin
            if (rx_count < HDR_BYTES_C) begin
                header_bytes[rx_count[HDR_IDX_W-1:0]] = b;
            end
            else begin
                offset = int'(rx_count) - HDR_BYTES;
                if (offset < int'(header_word(6))) begin
                    crc_run = crc16_step(crc_run, b);
                    if (copied < {8'h00, copy_max}) begin
                        copied++;
                        r.kind = KIND_PAYLOAD;
                        r.payload = b;
                        r.status = STATUS_OK;
                        r.eor = 1'b0;
                        awaited_results.push_back(r);
                    end
                end
            end
            rx_count++;
        end
        if (l) begin
            r.kind = KIND_VERDICT;
            r.payload = 8'h00;
            r.status = frame_status();
            r.eor = 1'b1;
            awaited_results.push_back(r);
            restart_frame();
        end
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_EXPECTED_TYPE:     want_type = data[7:0];
            REG_EXPECTED_SEQUENCE: want_seq = data;
            REG_CHECK_SEQUENCE:    seq_enabled = data[0];
            REG_COPY_LIMIT:        copy_max = data[7:0];
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t: %s", $time, msg);
    endtask

    task automatic check_result();
        result_t want;
        if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("result kind %0d arrived with nothing awaited", out_kind));
            return;
        end
        want = awaited_results.pop_front();
        if (out_kind !== want.kind)
            report_mismatch($sformatf("out_kind %0h, want %0h", out_kind, want.kind));
        if (payload_byte !== want.payload)
            report_mismatch($sformatf("payload_byte %0h, want %0h", payload_byte, want.payload));
        if (status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (end_of_run !== want.eor)
            report_mismatch($sformatf("end_of_run %0h, want %0h", end_of_run, want.eor));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            want_type = TYPE_AT_RESET;
            want_seq = SEQ_AT_RESET;
            seq_enabled = CHECK_AT_RESET;
            copy_max = COPY_AT_RESET;
            restart_frame();
            awaited_results.delete();
            mismatch_count = 0;
            pending <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
            if (in_valid && in_ready) predict_frame_results(rx_byte, first_byte, last_byte);
            if (out_valid && out_ready) check_result();
            pending <= awaited_results.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the response frame checker: clock, reset, frame stimulus,
// register writes, receiver back-pressure and the verdict. Depends on rfc_pkg,
// response_frame_checker_top and rfc_result_checker.
module tb_top;
    import rfc_pkg::*;

    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int STALL_LIMIT     = 2000;
    localparam int ITEMS_PER_SET   = 25;

    typedef enum int {
        FLAW_NONE,
        FLAW_SHORT,
        FLAW_MAGIC,
        FLAW_TYPE,
        FLAW_SEQUENCE,
        FLAW_TRUNCATED,
        FLAW_OVERSIZE,
        FLAW_CHECKSUM,
        FLAW_CUT
    } frame_flaw_e;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [7:0]             rx_byte = 8'h00;
    logic                   first_byte = 1'b0;
    logic                   last_byte = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   out_kind;
    logic [7:0]             payload_byte;
    logic [2:0]             status;
    logic                   end_of_run;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int                     mismatches;
    int                     pending;
    int                     send_idle_pct = 9;
    int                     recv_idle_pct = 77;
    logic                   hold_off_go = 1'b0;
    logic                   hold_off_done = 1'b0;
    int                     idle_cycles = 0;
    int                     sent_items = 0;

    logic [7:0]             cur_type = 8'h02;
    logic [15:0]            cur_seq = 16'h0000;
    logic                   cur_check = 1'b1;
    logic [7:0]             cur_copy = 8'd246;

    response_frame_checker_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .first_byte   (first_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_kind     (out_kind),
        .payload_byte (payload_byte),
        .status       (status),
        .end_of_run   (end_of_run),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    rfc_result_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .first_byte     (first_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_kind       (out_kind),
        .payload_byte   (payload_byte),
        .status         (status),
        .end_of_run     (end_of_run),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatches),
        .pending        (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hold off once on request, otherwise stall at the current rate
    always @(posedge clk)
    begin
        if (hold_off_go && !hold_off_done)
        begin
            out_ready <= 1'b0;
            hold_off_done = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        first_byte <= f;
        last_byte <= l;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_items++;
    endtask

    task automatic send_frame(input frame_flaw_e flaw, input int pay_len,
                              input logic mark_first, input int tail);
        logic [7:0]  body [$];
        logic [7:0]  head [HDR_BYTES];
        logic [7:0]  pay;
        logic [15:0] crc;
        logic [15:0] seq;
        logic [15:0] len_field;
        logic [7:0]  typ;
        int          keep;
        crc = CRC_INIT;
        typ = cur_type;
        seq = cur_check ? cur_seq : 16'($urandom_range(0, 65535));
        len_field = 16'(pay_len);
        case (flaw)
            FLAW_TYPE:      typ = cur_type ^ 8'($urandom_range(1, 255));
            FLAW_SEQUENCE:  seq = cur_seq ^ 16'($urandom_range(1, 65535));
            FLAW_TRUNCATED: len_field = 16'(pay_len + $urandom_range(1, 4));
            FLAW_OVERSIZE:  len_field = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                        : 16'($urandom_range(247, 65534));
            default: ;
        endcase
        for (int i = 0; i < pay_len; i++)
        begin
            pay = 8'($urandom);
            crc = crc_fold(crc, pay);
            body.push_back(pay);
        end
        if (flaw == FLAW_CHECKSUM) crc ^= 16'($urandom_range(1, 65535));
        head = '{FRAME_MAGIC[7:0], FRAME_MAGIC[15:8], 8'($urandom), typ,
                 seq[7:0], seq[15:8], len_field[7:0], len_field[15:8], crc[7:0], crc[15:8]};
        if (flaw == FLAW_MAGIC)
        begin
            keep = $urandom_range(0, 15);
            head[HDR_IDX_W'(keep / 8)] = head[HDR_IDX_W'(keep / 8)] ^ (8'h01 << (keep % 8));
        end
        for (int i = HDR_BYTES - 1; i >= 0; i--) body.push_front(head[i]);
        for (int i = 0; i < tail; i++) body.push_back(8'($urandom));
        keep = body.size();
        if (flaw == FLAW_SHORT) keep = $urandom_range(1, HDR_BYTES - 1);
        if (flaw == FLAW_CUT) keep = $urandom_range(1, body.size() - 1);
        for (int i = 0; i < keep; i++)
            send_byte(body[i], mark_first && (i == 0), (flaw != FLAW_CUT) && (i == keep - 1));
    endtask

    task automatic run_random_frames(input int count);
        int          target;
        int          pick;
        int          pay_len;
        frame_flaw_e flaw;
        target = sent_items + count;
        while (sent_items < target)
        begin
            pick = $urandom_range(0, 99);
            pay_len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 60)
                                                   : $urandom_range(0, 12);
            if (pick < 6)
            begin
                send_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
            end
            else
            begin
                flaw = (pick < 55) ? FLAW_NONE
                       : frame_flaw_e'($urandom_range(int'(FLAW_SHORT), int'(FLAW_CUT)));
                send_frame(flaw, pay_len, $urandom_range(0, 9) != 0,
                           (flaw == FLAW_NONE && $urandom_range(0, 3) == 0)
                           ? $urandom_range(1, 3) : 0);
            end
        end
        // close any open frame before the next register change
        send_frame(FLAW_NONE, $urandom_range(0, 4), 1'b1, 0);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [7:0] t, input logic [15:0] s,
                                 input logic c, input logic [7:0] lim);
        wait_idle();
        write_reg(REG_EXPECTED_TYPE, {8'h00, t});
        write_reg(REG_EXPECTED_SEQUENCE, s);
        write_reg(REG_CHECK_SEQUENCE, {15'h0000, c});
        write_reg(REG_COPY_LIMIT, {8'h00, lim});
        cur_type = t;
        cur_seq = s;
        cur_check = c;
        cur_copy = lim;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h00, 1'b1, 1'b1);
        send_frame(FLAW_NONE, 0, 1'b1, 0);
        send_frame(FLAW_NONE, 2, 1'b1, 0);
        send_byte(8'hFF, 1'b0, 1'b1);

        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:       begin send_idle_pct <= 9;  recv_idle_pct <= 77; end
                1:       begin send_idle_pct <= 77; recv_idle_pct <= 9;  end
                default: begin send_idle_pct <= 0;  recv_idle_pct <= 0;  end
            endcase
            for (int k = 0; k < 2; k++)
            begin
                case (mode * 2 + k)
                    0: apply_setting(8'h00, 16'hFFFF, 1'b1, 8'd0);
                    1: apply_setting(8'hFF, 16'h0000, 1'b0, 8'd246);
                    2: apply_setting(8'($urandom), 16'($urandom), 1'b1, 8'd3);
                    3: apply_setting(8'h02, 16'($urandom), 1'b0, 8'hFF);
                    4: apply_setting(8'($urandom), 16'($urandom), 1'b1, 8'($urandom_range(0, 10)));
                    default: apply_setting(8'h80, 16'h8000, 1'b1, 8'd246);
                endcase
                if (mode == 2 && k == 0) hold_off_go <= 1'b1;
                run_random_frames(ITEMS_PER_SET);
                if (mode == 2 && k == 1) send_frame(FLAW_NONE, 246, 1'b1, 10);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
